@@ hw/rtl/rbst_pkg.sv @@
// Shared widths and pipeline control type for the ray/box slab test.
// No dependencies; used by every module of the block.
`default_nettype none

package rbst_pkg;

    localparam int COORD_W = 32;            // Q16.16 inputs
    localparam int DIFF_W  = COORD_W + 1;   // corner minus origin, exact
    localparam int PROD_W  = 2 * COORD_W;   // Q32.32 distance, exact

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  dist_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

`default_nettype wire

@@ hw/rtl/ray_box_slab_test.sv @@
// Ray against axis-aligned box slab test. One word per cycle in unless stalled, one hit bit
// per word out; the pipeline depth is set by the exact 33 x 32 distance multiply in each
// axis unit and the two 64-bit compare stages behind it. Stalled stages hold while empty
// stages ahead of a stall still fill, so no word is lost or repeated.
// Depends on rbst_pkg, rbst_slab, rbst_merge.
`default_nettype none

module ray_box_slab_test
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] origin_x,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] origin_y,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] origin_z,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] inv_dir_x,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] inv_dir_y,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] inv_dir_z,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] box_min_x,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] box_min_y,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] box_min_z,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] box_max_x,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] box_max_y,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] box_max_z,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic      hit
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    rbst_pkg::pipe_en_t en;

    rbst_pkg::dist_t tx_near, tx_far, ty_near, ty_far, tz_near, tz_far;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        en.s4 = !v4_reg || !out_stall;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign in_stall  = !en.s1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1) v1_reg <= in_valid;
            if (en.s2) v2_reg <= v1_reg;
            if (en.s3) v3_reg <= v2_reg;
            if (en.s4) v4_reg <= v3_reg;
        end
    end

    rbst_slab u_slab_x
    (
        .clk     (clk),
        .en      (en),
        .origin  (origin_x),
        .inv_dir (inv_dir_x),
        .box_min (box_min_x),
        .box_max (box_max_x),
        .t_near  (tx_near),
        .t_far   (tx_far)
    );

    rbst_slab u_slab_y
    (
        .clk     (clk),
        .en      (en),
        .origin  (origin_y),
        .inv_dir (inv_dir_y),
        .box_min (box_min_y),
        .box_max (box_max_y),
        .t_near  (ty_near),
        .t_far   (ty_far)
    );

    rbst_slab u_slab_z
    (
        .clk     (clk),
        .en      (en),
        .origin  (origin_z),
        .inv_dir (inv_dir_z),
        .box_min (box_min_z),
        .box_max (box_max_z),
        .t_near  (tz_near),
        .t_far   (tz_far)
    );

    rbst_merge u_merge
    (
        .clk     (clk),
        .en      (en),
        .tx_near (tx_near),
        .tx_far  (tx_far),
        .ty_near (ty_near),
        .ty_far  (ty_far),
        .tz_near (tz_near),
        .tz_far  (tz_far),
        .hit     (hit)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rbst_slab.sv @@
// One axis of the slab test: corner select and difference, then exact multiply.
// Depends on rbst_pkg.
`default_nettype none

module rbst_slab
(
    input  wire logic              clk,
    input  wire rbst_pkg::pipe_en_t en,
    input  wire rbst_pkg::coord_t  origin,
    input  wire rbst_pkg::coord_t  inv_dir,
    input  wire rbst_pkg::coord_t  box_min,
    input  wire rbst_pkg::coord_t  box_max,
    output rbst_pkg::dist_t        t_near,
    output rbst_pkg::dist_t        t_far
);

    rbst_pkg::diff_t  near_diff_reg, near_diff_next;
    rbst_pkg::diff_t  far_diff_reg, far_diff_next;
    rbst_pkg::coord_t inv_reg;
    rbst_pkg::dist_t  t_near_reg, t_near_next;
    rbst_pkg::dist_t  t_far_reg, t_far_next;

    logic signed [rbst_pkg::PROD_W:0] near_full;
    logic signed [rbst_pkg::PROD_W:0] far_full;
    logic signed [rbst_pkg::PROD_W:0] inv_ext;

    // Negative inverse direction swaps the near and far corners.
    always_comb
    begin
        if (inv_dir[rbst_pkg::COORD_W-1])
        begin
            near_diff_next = {box_max[rbst_pkg::COORD_W-1], box_max}
                           - {origin[rbst_pkg::COORD_W-1], origin};
            far_diff_next  = {box_min[rbst_pkg::COORD_W-1], box_min}
                           - {origin[rbst_pkg::COORD_W-1], origin};
        end
        else
        begin
            near_diff_next = {box_min[rbst_pkg::COORD_W-1], box_min}
                           - {origin[rbst_pkg::COORD_W-1], origin};
            far_diff_next  = {box_max[rbst_pkg::COORD_W-1], box_max}
                           - {origin[rbst_pkg::COORD_W-1], origin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            near_diff_reg <= near_diff_next;
            far_diff_reg  <= far_diff_next;
            inv_reg       <= inv_dir;
        end
    end

    // 33 x 32 signed products; the result always fits in 64 bits.
    always_comb
    begin
        inv_ext   = {{(rbst_pkg::PROD_W + 1 - rbst_pkg::COORD_W){inv_reg[rbst_pkg::COORD_W-1]}},
                     inv_reg};
        near_full = {{(rbst_pkg::PROD_W + 1 - rbst_pkg::DIFF_W){near_diff_reg[rbst_pkg::DIFF_W-1]}},
                     near_diff_reg} * inv_ext;
        far_full  = {{(rbst_pkg::PROD_W + 1 - rbst_pkg::DIFF_W){far_diff_reg[rbst_pkg::DIFF_W-1]}},
                     far_diff_reg} * inv_ext;
        t_near_next = near_full[rbst_pkg::PROD_W-1:0];
        t_far_next  = far_full[rbst_pkg::PROD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            t_near_reg <= t_near_next;
            t_far_reg  <= t_far_next;
        end
    end

    assign t_near = t_near_reg;
    assign t_far  = t_far_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rbst_merge.sv @@
// Interval merge: X/Y intersection in one stage, Z test and hit in the next.
// Depends on rbst_pkg.
`default_nettype none

module rbst_merge
(
    input  wire logic              clk,
    input  wire rbst_pkg::pipe_en_t en,
    input  wire rbst_pkg::dist_t   tx_near,
    input  wire rbst_pkg::dist_t   tx_far,
    input  wire rbst_pkg::dist_t   ty_near,
    input  wire rbst_pkg::dist_t   ty_far,
    input  wire rbst_pkg::dist_t   tz_near,
    input  wire rbst_pkg::dist_t   tz_far,
    output logic                   hit
);

    rbst_pkg::dist_t t_lo_reg, t_lo_next;
    rbst_pkg::dist_t t_hi_reg, t_hi_next;
    rbst_pkg::dist_t tz_near_reg, tz_far_reg;
    logic            xy_miss_reg, xy_miss_next;
    logic            hit_reg, hit_next;

    always_comb
    begin
        xy_miss_next = (tx_near > ty_far) || (ty_near > tx_far);
        t_lo_next    = (ty_near > tx_near) ? ty_near : tx_near;
        t_hi_next    = (ty_far < tx_far) ? ty_far : tx_far;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            t_lo_reg    <= t_lo_next;
            t_hi_reg    <= t_hi_next;
            tz_near_reg <= tz_near;
            tz_far_reg  <= tz_far;
            xy_miss_reg <= xy_miss_next;
        end
    end

    // Touching intervals still count as a hit.
    assign hit_next = !xy_miss_reg && !((t_lo_reg > tz_far_reg) || (tz_near_reg > t_hi_reg));

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire
